// ----- hw/rtl/sliding_window_letter_entropy_unit_assert.svh -----
// Assertion macros shared by the letter entropy RTL.
// Needs nothing else; files that check their logic include this header.
`ifndef SLIDING_WINDOW_LETTER_ENTROPY_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_LETTER_ENTROPY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SWLE_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SWLE_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/swle_pkg.sv -----
// Shared types, constants and elaboration-time table builders for the
// sliding window letter entropy unit. Depends on nothing.
package swle_pkg;

  localparam int MAX_WINDOW_DEFAULT    = 64;
  localparam int ALPHABET_SIZE_DEFAULT = 26;

  localparam int CFG_W    = 7;
  localparam int LETTER_W = 5;
  localparam int ENT_W    = 15;

  localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd12;

  typedef struct packed {
    logic [LETTER_W-1:0] letter_code;
    logic                end_of_sequence;
  } swle_in_t;

  typedef struct packed {
    logic             window_full;
    logic [ENT_W-1:0] entropy;
    logic             last_of_sequence;
  } swle_out_t;

  // Per-item control that travels alongside the letter.
  typedef struct packed {
    logic evict;  // the window was full, so the oldest letter leaves
    logic full;   // the window is full after this letter enters
    logic eos;    // last letter of the sequence
  } swle_tag_t;

  // log2(n) with 24 fraction bits: top set bit, then 24 rounds of squaring
  // a 30-fraction-bit mantissa, each square truncated.
  function automatic logic [31:0] log2_q24(input int unsigned n);
    int unsigned       k;
    longint unsigned   m;
    longint unsigned   frac;
    longint unsigned   nl;
    k    = 0;
    frac = 0;
    nl   = n;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    m = (nl << 30) >> k;
    for (int r = 0; r < 24; r++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    return 32'((longint'(k) << 24) | frac);
  endfunction

  // c * log2(c) in Q.12, rounded half up; zero for c = 0.
  function automatic logic [31:0] plog_q12(input int unsigned c);
    longint unsigned cl;
    longint unsigned lg;
    cl = c;
    lg = log2_q24(c);
    if (c == 0) return 32'd0;
    return 32'((cl * lg + 64'd2048) >> 12);
  endfunction

  // log2(w) in Q4.12, rounded half up.
  function automatic logic [31:0] lg_q12(input int unsigned w);
    longint unsigned lg;
    lg = log2_q24(w);
    if (w == 0) return 32'd0;
    return 32'((lg + 64'd2048) >> 12);
  endfunction

  // ceil(2^sh / d) by restoring long division, one bit per round.
  function automatic longint unsigned recip_ceil(input int unsigned d, input int unsigned sh);
    longint unsigned num;
    longint unsigned rem;
    longint unsigned q;
    longint unsigned dl;
    dl  = d;
    num = (64'd1 << sh) + dl - 64'd1;
    rem = 0;
    q   = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 64'd1);
      if (rem >= dl) begin
        rem = rem - dl;
        q   = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // Width of the running sum: the largest value is one letter filling the window.
  function automatic int sum_width(input int max_window);
    return $clog2(plog_q12(max_window) + 32'd1);
  endfunction

endpackage

// ----- hw/rtl/sliding_window_letter_entropy_unit.sv -----
// Sliding window letter entropy unit, top level; uses swle_pkg, swle_ram,
// swle_counts, swle_entropy and the assertion header.
// Throughput: one beat per cycle unless out_ready holds the output. Each
// letter passes the count stage, then the sum, quotient and output registers.
// Synchronous active-high reset clears counts, sum, fill and pointer; the
// window length returns to 12. No clearing pass is needed after reset.
`include "sliding_window_letter_entropy_unit_assert.svh"

module sliding_window_letter_entropy_unit import swle_pkg::*; #(
  parameter int MAX_WINDOW    = MAX_WINDOW_DEFAULT,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  swle_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output swle_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int LET_W = $clog2(ALPHABET_SIZE);
  localparam int SUM_W = sum_width(MAX_WINDOW);

  // Configuration: the window length register. A write always restarts the
  // sequence. Writes are only expected while the block is idle, so the port
  // is always ready.
  logic [CFG_W-1:0] window_len;
  logic [CNT_W-1:0] win_w;
  logic             cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // A length of zero acts as one; anything beyond the window store saturates.
  always_comb begin
    if (window_len == '0) begin
      win_w = CNT_W'(1);
    end else if (int'(window_len) > MAX_WINDOW) begin
      win_w = CNT_W'(MAX_WINDOW);
    end else begin
      win_w = CNT_W'(window_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
    end else if (cfg_fire) begin
      window_len <= cfg_data;
    end
  end

  // Front end. The write pointer and fill count depend only on how many
  // letters the sequence has had, so they advance on acceptance. That lets
  // the window RAM be read for the leaving letter as the new one is accepted.
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] ptr_next;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [PTR_W-1:0] wp_now;
  logic [CNT_W-1:0] wp_inc;
  logic [LET_W-1:0] letter_in;
  swle_tag_t        tag_in;
  logic             in_fire;

  // Count stage registers.
  logic             s1_valid;
  logic [LET_W-1:0] s1_letter;
  logic [PTR_W-1:0] s1_wp;
  swle_tag_t        s1_tag;
  logic             s1_byp_hit;
  logic [LET_W-1:0] s1_byp_letter;
  logic             s1_advance;
  logic             ent_ready;
  logic [LET_W-1:0] ram_rdata;
  logic [LET_W-1:0] old_letter;
  logic [SUM_W-1:0] sum_after;

  assign in_fire    = in_valid && in_ready;
  assign s1_advance = s1_valid && ent_ready;
  assign in_ready   = !s1_valid || s1_advance;

  always_comb begin
    wp_now    = (CNT_W'(ptr) >= win_w) ? '0 : ptr;
    wp_inc    = CNT_W'(wp_now) + CNT_W'(1);
    ptr_next  = (wp_inc >= win_w) ? '0 : wp_inc[PTR_W-1:0];
    fill_next = (fill < win_w) ? fill + CNT_W'(1) : fill;
    tag_in.evict = (fill >= win_w);
    tag_in.full  = (fill_next >= win_w);
    tag_in.eos   = in_data.end_of_sequence;
    // Codes past the alphabet are counted as its last letter.
    letter_in = (int'(in_data.letter_code) >= ALPHABET_SIZE) ? LET_W'(ALPHABET_SIZE - 1)
                                                             : in_data.letter_code[LET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      ptr  <= '0;
      fill <= '0;
    end else if (in_fire) begin
      if (in_data.end_of_sequence) begin
        ptr  <= '0;
        fill <= '0;
      end else begin
        ptr  <= ptr_next;
        fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // The letter in the count stage writes the RAM in the same cycle that the
  // next letter reads it. When both hit the same entry (a window of one), the
  // written letter is forwarded instead of the stale RAM word.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_letter     <= letter_in;
      s1_wp         <= wp_now;
      s1_tag        <= tag_in;
      s1_byp_hit    <= s1_advance && (s1_wp == wp_now);
      s1_byp_letter <= s1_letter;
    end
  end

  assign old_letter = s1_byp_hit ? s1_byp_letter : ram_rdata;

  swle_ram #(
    .WIDTH (LET_W),
    .DEPTH (MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (s1_advance),
    .waddr (s1_wp),
    .wdata (s1_letter),
    .re    (in_fire),
    .raddr (wp_now),
    .rdata (ram_rdata)
  );

  // Count lanes and running sum, carried from one letter to the next; each
  // update is combinational from the registered counts and sum.
  swle_counts #(
    .MAX_WINDOW    (MAX_WINDOW),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_counts (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_fire),
    .step       (s1_advance),
    .tag        (s1_tag),
    .new_letter (s1_letter),
    .old_letter (old_letter),
    .sum_after  (sum_after)
  );

  // Divide, subtract and the output register; its ready stalls the stages
  // above only when every one of its stages is occupied.
  swle_entropy #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_entropy (
    .clk       (clk),
    .rst       (rst),
    .win_w     (win_w),
    .in_valid  (s1_valid),
    .in_ready  (ent_ready),
    .sum       (sum_after),
    .tag       (s1_tag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `SWLE_CHECK(a_wp_in_window, clk, rst, in_fire, CNT_W'(wp_now) < win_w, "write pointer outside window")
  `SWLE_CHECK(a_fill_bounded, clk, rst, 1'b1, fill <= win_w, "fill count exceeds window length")
  `SWLE_CHECK_NEXT(a_cfg_restarts, clk, rst, cfg_fire, fill == '0 && ptr == '0, "length write did not restart sequence")

endmodule

// ----- hw/rtl/swle_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module swle_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/swle_counts.sv -----
// Per-letter count lanes and the running sum of c*log2(c) terms.
// Depends on swle_pkg and the assertion header.
`include "sliding_window_letter_entropy_unit_assert.svh"

module swle_counts import swle_pkg::*; #(
  parameter int MAX_WINDOW    = MAX_WINDOW_DEFAULT,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEFAULT,
  localparam int CNT_W = $clog2(MAX_WINDOW + 1),
  localparam int LET_W = $clog2(ALPHABET_SIZE),
  localparam int SUM_W = sum_width(MAX_WINDOW)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             step,
  input  swle_tag_t        tag,
  input  logic [LET_W-1:0] new_letter,
  input  logic [LET_W-1:0] old_letter,
  output logic [SUM_W-1:0] sum_after
);

  logic [CNT_W-1:0] cnt      [ALPHABET_SIZE];
  logic [CNT_W-1:0] cnt_next [ALPHABET_SIZE];
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] plog_tab [0:MAX_WINDOW];
  logic [LET_W-1:0] old_clamped;
  logic [SUM_W-1:0] d_new;
  logic [SUM_W-1:0] d_old;

  for (genvar c = 0; c <= MAX_WINDOW; c++) begin : g_plog
    assign plog_tab[c] = SUM_W'(plog_q12(c));
  end

  // Each lane applies the leave, then the enter, to its own count. At most
  // two lanes change, so their sum deltas are picked out by one-hot OR.
  always_comb begin
    logic             hit_old;
    logic             hit_new;
    logic [CNT_W-1:0] c1;
    logic [CNT_W-1:0] c2;
    logic [SUM_W-1:0] delta;
    old_clamped = (int'(old_letter) >= ALPHABET_SIZE) ? LET_W'(ALPHABET_SIZE - 1)
                                                      : old_letter;
    d_new = '0;
    d_old = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      hit_old = tag.evict && (old_clamped == LET_W'(i));
      hit_new = (new_letter == LET_W'(i));
      c1 = (hit_old && cnt[i] != '0) ? cnt[i] - CNT_W'(1) : cnt[i];
      c2 = (hit_new && c1 < CNT_W'(MAX_WINDOW)) ? c1 + CNT_W'(1) : c1;
      cnt_next[i] = c2;
      delta = plog_tab[c2] - plog_tab[cnt[i]];
      if (hit_new) begin
        d_new = d_new | delta;
      end else if (hit_old) begin
        d_old = d_old | delta;
      end
    end
    sum_after = sum + d_new + d_old;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sum <= '0;
      for (int i = 0; i < ALPHABET_SIZE; i++) cnt[i] <= '0;
    end else if (step) begin
      if (tag.eos) begin
        sum <= '0;
        for (int i = 0; i < ALPHABET_SIZE; i++) cnt[i] <= '0;
      end else begin
        sum <= sum_after;
        for (int i = 0; i < ALPHABET_SIZE; i++) cnt[i] <= cnt_next[i];
      end
    end
  end

  `SWLE_CHECK_NEXT(a_sum_restarts, clk, rst, clear || (step && tag.eos), sum == '0, "sum not cleared at sequence start")

endmodule

// ----- hw/rtl/swle_entropy.sv -----
// Entropy back end: divide the sum by the window length through a reciprocal
// table, subtract from log2 of the length (zero until the window is full), and hold the result beat.
// Depends on swle_pkg.
module swle_entropy import swle_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT,
  localparam int CNT_W = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W = sum_width(MAX_WINDOW)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] win_w,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SUM_W-1:0] sum,
  input  swle_tag_t        tag,
  output logic             out_valid,
  input  logic             out_ready,
  output swle_out_t        out_data
);

  // With N below 2^N_W and a shift of N_W plus ceil(log2 of the largest
  // length), the rounded-up reciprocal gives the exact floor quotient.
  localparam int N_W    = SUM_W + 1;
  localparam int SH     = N_W + $clog2(MAX_WINDOW);
  localparam int REC_W  = SH + 1;
  localparam int PROD_W = N_W + REC_W;
  localparam int LG_W   = $clog2(lg_q12(MAX_WINDOW) + 32'd1);

  logic [REC_W-1:0] recip_tab [0:MAX_WINDOW];
  logic [LG_W-1:0]  lg_tab    [0:MAX_WINDOW];

  for (genvar c = 0; c <= MAX_WINDOW; c++) begin : g_tab
    assign recip_tab[c] = (c == 0) ? '0 : REC_W'(recip_ceil(c, SH));
    assign lg_tab[c]    = LG_W'(lg_q12(c));
  end

  logic             s2_valid;
  logic [SUM_W-1:0] s2_sum;
  swle_tag_t        s2_tag;
  logic             s3_valid;
  logic [N_W-1:0]   s3_q;
  swle_tag_t        s3_tag;

  logic             out_free;
  logic             s3_free;
  logic             s2_free;
  logic [N_W-1:0]   n_val;
  logic [PROD_W-1:0] prod;
  logic [N_W-1:0]   q_est;
  logic [N_W-1:0]   lg_ext;
  logic [N_W-1:0]   ent_full;
  swle_out_t        result;

  assign out_free = !out_valid || out_ready;
  assign s3_free  = !s3_valid || out_free;
  assign s2_free  = !s2_valid || s3_free;
  assign in_ready = s2_free;

  always_comb begin
    n_val  = N_W'(s2_sum) + N_W'(win_w >> 1);
    prod   = PROD_W'(n_val) * PROD_W'(recip_tab[win_w]);
    q_est  = prod[SH +: N_W];
    lg_ext = N_W'(lg_tab[win_w]);
    ent_full = (lg_ext > s3_q) ? lg_ext - s3_q : '0;
    result.window_full      = s3_tag.full;
    result.entropy          = s3_tag.full ? ent_full[ENT_W-1:0] : '0;
    result.last_of_sequence = s3_tag.eos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_free) s2_valid <= in_valid;
      if (s3_free) s3_valid <= s2_valid;
      if (out_free) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && in_valid) begin
      s2_sum <= sum;
      s2_tag <= tag;
    end
    if (s3_free && s2_valid) begin
      s3_q   <= q_est;
      s3_tag <= s2_tag;
    end
    if (out_free && s3_valid) begin
      out_data <= result;
    end
  end

endmodule
